// ===== hdl/bqlp_pkg.sv =====
`default_nettype none

package bqlp_pkg;

  localparam int SAMPLE_W = 24;
  localparam int COEF_W   = 24;
  localparam int FRAC_W   = 20;
  localparam int PROD_W   = SAMPLE_W + COEF_W;
  localparam int ACC_W    = PROD_W + 3;
  localparam int IDX_W    = 3;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic signed [ACC_W-1:0]    acc_t;

  localparam acc_t ACC_RND = acc_t'(1) << (FRAC_W - 1);
  localparam acc_t ACC_MAX = {{(ACC_W - SAMPLE_W + 1){1'b0}}, {(SAMPLE_W - 1){1'b1}}};
  localparam acc_t ACC_MIN = {{(ACC_W - SAMPLE_W + 1){1'b1}}, {(SAMPLE_W - 1){1'b0}}};

  typedef enum logic [IDX_W-1:0] {
    REG_B0,
    REG_B1,
    REG_B2,
    REG_FB1,
    REG_FB2,
    REG_BYPASS
  } reg_idx_t;

  typedef struct packed {
    coef_t b0;
    coef_t b1;
    coef_t b2;
    coef_t fb1;
    coef_t fb2;
    logic  bypass;
  } coefs_t;

  typedef struct packed {
    sample_t x;
    logic    mark;
    prod_t   p0;
    prod_t   p1;
    prod_t   p2;
  } ff_req_t;

endpackage

`default_nettype wire

// ===== hdl/biquad_lowpass_filter.sv =====
// Channel   Signals                                   Moves
// sample    sample_valid/ready, sample_in, block_end_in   one input request
// result    result_valid/ready, sample_out, block_end_out one filtered sample
// cfg       cfg_valid/ready, cfg_index, cfg_data          one register write
//
// One sample per cycle sustained while result_ready stays high; each sample passes the input
// register, the feed-forward products register and the feedback and rounding register in turn.
// The feedback multiplies, sum, rounding and saturation are combinational ahead of the output register.
// Reset clears the history to zero, coefficients to zero and sets bypass.
// Each stage holds while the next is full and stalled; bubbles collapse.
`default_nettype none

module biquad_lowpass_filter (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          sample_valid,
  output logic                         sample_ready,
  input  wire  [bqlp_pkg::SAMPLE_W-1:0] sample_in,
  input  wire                          block_end_in,
  output logic                         result_valid,
  input  wire                          result_ready,
  output logic [bqlp_pkg::SAMPLE_W-1:0] sample_out,
  output logic                         block_end_out,
  input  wire                          cfg_valid,
  output logic                         cfg_ready,
  input  wire  [bqlp_pkg::IDX_W-1:0]   cfg_index,
  input  wire  [bqlp_pkg::COEF_W-1:0]  cfg_data
);
  import bqlp_pkg::*;

  coefs_t  coefs;
  logic    s1_valid;
  sample_t s1_x;
  logic    s1_mark;
  logic    ff_ready;
  logic    ff_valid;
  ff_req_t ff_req;
  logic    fb_ready;
  sample_t y_out;

  assign sample_ready = !s1_valid || ff_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (sample_valid && sample_ready) begin
      s1_valid <= 1'b1;
    end else if (ff_ready) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_valid && sample_ready) begin
      s1_x    <= sample_in;
      s1_mark <= block_end_in;
    end
  end

  bqlp_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .coefs     (coefs)
  );

  bqlp_ff u_ff (
    .clk      (clk),
    .rst      (rst),
    .coefs    (coefs),
    .up_valid (s1_valid),
    .up_ready (ff_ready),
    .up_x     (s1_x),
    .up_mark  (s1_mark),
    .dn_valid (ff_valid),
    .dn_ready (fb_ready),
    .dn_req   (ff_req)
  );

  bqlp_fb u_fb (
    .clk       (clk),
    .rst       (rst),
    .coefs     (coefs),
    .up_valid  (ff_valid),
    .up_ready  (fb_ready),
    .up_req    (ff_req),
    .dn_valid  (result_valid),
    .dn_ready  (result_ready),
    .dn_sample (y_out),
    .dn_mark   (block_end_out)
  );

  assign sample_out = y_out;

endmodule

`default_nettype wire

// ===== hdl/bqlp_cfg.sv =====
`default_nettype none

module bqlp_cfg (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          cfg_valid,
  output logic                         cfg_ready,
  input  wire  [bqlp_pkg::IDX_W-1:0]   cfg_index,
  input  wire  [bqlp_pkg::COEF_W-1:0]  cfg_data,
  output bqlp_pkg::coefs_t             coefs
);
  import bqlp_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      coefs.b0     <= '0;
      coefs.b1     <= '0;
      coefs.b2     <= '0;
      coefs.fb1    <= '0;
      coefs.fb2    <= '0;
      coefs.bypass <= 1'b1;
    end else if (cfg_valid) begin
      case (reg_idx_t'(cfg_index))
        REG_B0:     coefs.b0     <= cfg_data;
        REG_B1:     coefs.b1     <= cfg_data;
        REG_B2:     coefs.b2     <= cfg_data;
        REG_FB1:    coefs.fb1    <= cfg_data;
        REG_FB2:    coefs.fb2    <= cfg_data;
        REG_BYPASS: coefs.bypass <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hdl/bqlp_ff.sv =====
`default_nettype none

module bqlp_ff (
  input  wire                  clk,
  input  wire                  rst,
  input  wire bqlp_pkg::coefs_t  coefs,
  input  wire                  up_valid,
  output logic                 up_ready,
  input  wire bqlp_pkg::sample_t up_x,
  input  wire                  up_mark,
  output logic                 dn_valid,
  input  wire                  dn_ready,
  output bqlp_pkg::ff_req_t    dn_req
);
  import bqlp_pkg::*;

  sample_t x1;
  sample_t x2;
  prod_t   p0;
  prod_t   p1;
  prod_t   p2;
  logic    take;

  assign up_ready = !dn_valid || dn_ready;
  assign take     = up_valid && up_ready;

  assign p0 = up_x * coefs.b0;
  assign p1 = x1 * coefs.b1;
  assign p2 = x2 * coefs.b2;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
      x1       <= '0;
      x2       <= '0;
    end else if (take) begin
      dn_valid <= 1'b1;
      if (!coefs.bypass) begin
        x1 <= up_x;
        x2 <= x1;
      end
    end else if (dn_ready) begin
      dn_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      dn_req.x    <= up_x;
      dn_req.mark <= up_mark;
      dn_req.p0   <= p0;
      dn_req.p1   <= p1;
      dn_req.p2   <= p2;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/bqlp_fb.sv =====
`default_nettype none

module bqlp_fb (
  input  wire                  clk,
  input  wire                  rst,
  input  wire bqlp_pkg::coefs_t  coefs,
  input  wire                  up_valid,
  output logic                 up_ready,
  input  wire bqlp_pkg::ff_req_t up_req,
  output logic                 dn_valid,
  input  wire                  dn_ready,
  output bqlp_pkg::sample_t    dn_sample,
  output logic                 dn_mark
);
  import bqlp_pkg::*;

  sample_t y1;
  sample_t y2;
  prod_t   q1;
  prod_t   q2;
  acc_t    acc;
  acc_t    shifted;
  sample_t y_sat;
  logic    take;

  assign up_ready = !dn_valid || dn_ready;
  assign take     = up_valid && up_ready;

  assign q1 = y1 * coefs.fb1;
  assign q2 = y2 * coefs.fb2;

  always_comb begin
    acc = acc_t'(up_req.p0) + acc_t'(up_req.p1) + acc_t'(up_req.p2)
        - acc_t'(q1) - acc_t'(q2) + ACC_RND;
    shifted = acc >>> FRAC_W;
    if (shifted > ACC_MAX) begin
      y_sat = sample_t'(ACC_MAX);
    end else if (shifted < ACC_MIN) begin
      y_sat = sample_t'(ACC_MIN);
    end else begin
      y_sat = sample_t'(shifted);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
      y1       <= '0;
      y2       <= '0;
    end else if (take) begin
      dn_valid <= 1'b1;
      if (!coefs.bypass) begin
        y1 <= y_sat;
        y2 <= y1;
      end
    end else if (dn_ready) begin
      dn_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      dn_sample <= coefs.bypass ? up_req.x : y_sat;
      dn_mark   <= up_req.mark;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/bqlp_checker.sv =====
`default_nettype none

module bqlp_checker (
  input wire                          clk,
  input wire                          rst,
  input wire                          sample_valid,
  input wire                          sample_ready,
  input wire [bqlp_pkg::SAMPLE_W-1:0] sample_in,
  input wire                          block_end_in,
  input wire                          result_valid,
  input wire                          result_ready,
  input wire [bqlp_pkg::SAMPLE_W-1:0] sample_out,
  input wire                          block_end_out,
  input wire                          cfg_valid,
  input wire                          cfg_ready
);

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid && sample_ready)
    else $error("pipeline not empty after reset");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=>
      result_valid && $stable(sample_out) && $stable(block_end_out))
    else $error("stalled result changed");

  a_request_hold: assert property (@(posedge clk) disable iff (rst)
    sample_valid && !sample_ready |=>
      sample_valid && $stable(sample_in) && $stable(block_end_in))
    else $error("waiting request changed");

  a_ready_flow: assert property (@(posedge clk) disable iff (rst)
    result_ready |-> sample_ready)
    else $error("input stalled while output drains");

  a_cfg_open: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("configuration write refused");

endmodule

bind biquad_lowpass_filter bqlp_checker u_bqlp_checker (.*);

`default_nettype wire

// ===== dv/biquad_lowpass_filter_tb.sv =====
`default_nettype none

module biquad_lowpass_filter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bqlp_pkg::*;

  localparam sample_t SAMPLE_MAX = sample_t'((1 << (SAMPLE_W - 1)) - 1);
  localparam sample_t SAMPLE_MIN = sample_t'(1 << (SAMPLE_W - 1));
  localparam coef_t COEF_MAX = coef_t'((1 << (COEF_W - 1)) - 1);
  localparam coef_t COEF_MIN = coef_t'(1 << (COEF_W - 1));
  localparam coef_t UNITY = coef_t'(1 << FRAC_W);
  localparam coef_t HALF = coef_t'(1 << (FRAC_W - 1));
  localparam longint SAT_HI = (longint'(1) << (SAMPLE_W - 1)) - 1;
  localparam longint SAT_LO = -SAT_HI - 1;
  localparam logic [IDX_W-1:0] IDX_SPARE_FIRST = REG_BYPASS + 1'b1;
  localparam logic [IDX_W-1:0] IDX_SPARE_LAST = '1;
  localparam int LATENCY = 3;

  typedef struct {
    sample_t level;
    logic    block_end;
  } filtered_t;

  logic                clk;
  logic                rst;
  logic                sample_valid;
  logic                sample_ready;
  logic [SAMPLE_W-1:0] sample_in;
  logic                block_end_in;
  logic                result_valid;
  logic                result_ready;
  logic [SAMPLE_W-1:0] sample_out;
  logic                block_end_out;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [IDX_W-1:0]    cfg_index;
  logic [COEF_W-1:0]   cfg_data;

  longint gain_b0, gain_b1, gain_b2, gain_fb1, gain_fb2;
  bit     bypass_on;
  longint x_hist1, x_hist2, y_hist1, y_hist2;

  filtered_t   pending_outputs[$];
  int unsigned mismatch_count = 0;
  int unsigned hold_cycles = 0;
  bit          idle_on = 1'b1;

  biquad_lowpass_filter uut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample_in    (sample_in),
    .block_end_in (block_end_in),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .sample_out   (sample_out),
    .block_end_out(block_end_out),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("biquad_lowpass_filter regression: fail");
    $finish;
  end

  function automatic int unsigned draw_gap();
    return idle_on ? $urandom_range(0, 3) : 0;
  endfunction

  function automatic sample_t draw_sample();
    case ($urandom_range(0, 7))
      0: return SAMPLE_MAX;
      1: return SAMPLE_MIN;
      2: return sample_t'(int'($urandom_range(0, 512)) - 256);
      default: return sample_t'($urandom);
    endcase
  endfunction

  function automatic logic draw_block_end();
    return $urandom_range(0, 7) == 0;
  endfunction

  function automatic sample_t filter_sample(sample_t x);
    longint acc;
    longint y;
    if (bypass_on) return x;
    acc = gain_b0 * longint'(x) + gain_b1 * x_hist1 + gain_b2 * x_hist2
        - gain_fb1 * y_hist1 - gain_fb2 * y_hist2;
    acc += longint'(1) << (FRAC_W - 1);
    y = acc >>> FRAC_W;
    if (y > SAT_HI) y = SAT_HI;
    if (y < SAT_LO) y = SAT_LO;
    x_hist2 = x_hist1;
    x_hist1 = longint'(x);
    y_hist2 = y_hist1;
    y_hist1 = y;
    return sample_t'(y);
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t ns mismatch %s: got %0d expected %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  task automatic send_sample(sample_t x, logic block_end);
    int unsigned gap;
    filtered_t   predicted;
    gap = draw_gap();
    @(negedge clk);
    if (gap > 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    sample_valid <= 1'b1;
    sample_in <= x;
    block_end_in <= block_end;
    do @(posedge clk); while (!sample_ready);
    predicted.level = filter_sample(x);
    predicted.block_end = block_end;
    pending_outputs.push_back(predicted);
  endtask

  task automatic drain_results();
    @(negedge clk);
    sample_valid <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(logic [IDX_W-1:0] idx, logic [COEF_W-1:0] data);
    int unsigned gap;
    drain_results();
    gap = draw_gap();
    repeat (gap) @(negedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_B0:     gain_b0 = longint'(coef_t'(data));
      REG_B1:     gain_b1 = longint'(coef_t'(data));
      REG_B2:     gain_b2 = longint'(coef_t'(data));
      REG_FB1:    gain_fb1 = longint'(coef_t'(data));
      REG_FB2:    gain_fb2 = longint'(coef_t'(data));
      REG_BYPASS: bypass_on = data[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_coefficients(coef_t b0, coef_t b1, coef_t b2, coef_t fb1, coef_t fb2,
                                   logic byp);
    logic [COEF_W-1:0] byp_word;
    byp_word = COEF_W'($urandom);
    byp_word[0] = byp;
    cfg_write(REG_B0, b0);
    cfg_write(REG_B1, b1);
    cfg_write(REG_B2, b2);
    cfg_write(REG_FB1, fb1);
    cfg_write(REG_FB2, fb2);
    cfg_write(REG_BYPASS, byp_word);
  endtask

  task automatic test_pass_through();
    send_sample('0, 1'b0);
    send_sample(sample_t'(1), 1'b1);
    send_sample(sample_t'(-1), 1'b0);
    send_sample(SAMPLE_MAX, 1'b1);
    send_sample(SAMPLE_MIN, 1'b0);
  endtask

  task automatic test_unity_gain();
    load_coefficients(UNITY, '0, '0, '0, '0, 1'b0);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(SAMPLE_MIN, 1'b1);
    send_sample(draw_sample(), 1'b0);
  endtask

  task automatic test_half_rounding();
    cfg_write(REG_B0, HALF);
    send_sample(sample_t'(1), 1'b0);
    send_sample(sample_t'(-1), 1'b0);
    send_sample(sample_t'(3), 1'b1);
    send_sample(sample_t'(-3), 1'b0);
  endtask

  task automatic test_saturation();
    load_coefficients(COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX, 1'b0);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample(SAMPLE_MAX, 1'b1);
    send_sample(SAMPLE_MIN, 1'b0);
  endtask

  task automatic test_spare_index();
    load_coefficients(HALF, UNITY, HALF, coef_t'(-int'(HALF)), HALF, 1'b0);
    cfg_write(IDX_SPARE_FIRST, COEF_W'($urandom));
    cfg_write(IDX_SPARE_LAST, COEF_W'($urandom));
    send_sample(draw_sample(), 1'b0);
    send_sample(draw_sample(), 1'b1);
  endtask

  task automatic test_bypass_keeps_history();
    send_sample(sample_t'(12345), 1'b0);
    cfg_write(REG_BYPASS, COEF_W'(1));
    send_sample(sample_t'(-777), 1'b0);
    send_sample(SAMPLE_MAX, 1'b1);
    cfg_write(REG_BYPASS, '0);
    send_sample(sample_t'(4096), 1'b0);
    send_sample(sample_t'(-4096), 1'b0);
  endtask

  task automatic test_random_coefficients();
    coef_t coefs[5];
    int    g;
    for (int phase = 0; phase < 9; phase++) begin
      idle_on = (phase != 5);
      case (phase % 5)
        0: begin
          g = $urandom_range(1, 20000);
          coefs = '{coef_t'(g), coef_t'(2 * g), coef_t'(g),
                    coef_t'(-int'($urandom_range(1500000, 2000000))),
                    coef_t'($urandom_range(600000, 1000000))};
        end
        1: foreach (coefs[i]) coefs[i] = coef_t'($urandom);
        2: coefs = '{COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX};
        3: coefs = '{COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN};
        default: foreach (coefs[i]) coefs[i] = coef_t'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
      endcase
      load_coefficients(coefs[0], coefs[1], coefs[2], coefs[3], coefs[4], phase == 7);
      if (phase == 4) cfg_write(IDX_SPARE_FIRST + IDX_W'($urandom_range(0, 1)), COEF_W'($urandom));
      repeat (50) send_sample(draw_sample(), draw_block_end());
    end
    idle_on = 1'b1;
  endtask

  task automatic test_output_stall();
    idle_on = 1'b0;
    load_coefficients(HALF, HALF, '0, coef_t'(-int'(HALF)), '0, 1'b0);
    send_sample(draw_sample(), 1'b0);
    hold_cycles = 80;
    repeat (40) send_sample(draw_sample(), draw_block_end());
    drain_results();
    idle_on = 1'b1;
  endtask

  initial begin
    int unsigned stall;
    result_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_cycles > 0) begin
        stall = hold_cycles;
        hold_cycles = 0;
      end else begin
        stall = draw_gap();
      end
      @(negedge clk);
      if (stall > 0) begin
        result_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      result_ready <= 1'b1;
      do @(posedge clk); while (!result_valid);
    end
  end

  always @(posedge clk) begin
    filtered_t want;
    if (!rst && result_valid && result_ready) begin
      if (pending_outputs.size() == 0) begin
        report_mismatch("result with no request", longint'(sample_t'(sample_out)), 0);
      end else begin
        want = pending_outputs.pop_front();
        if (sample_t'(sample_out) !== want.level)
          report_mismatch("sample_out", longint'(sample_t'(sample_out)), longint'(want.level));
        if (block_end_out !== want.block_end)
          report_mismatch("block_end_out", longint'(block_end_out), longint'(want.block_end));
      end
    end
  end

  initial begin
    rst = 1'b1;
    sample_valid = 1'b0;
    sample_in = '0;
    block_end_in = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    gain_b0 = 0;
    gain_b1 = 0;
    gain_b2 = 0;
    gain_fb1 = 0;
    gain_fb2 = 0;
    bypass_on = 1'b1;
    x_hist1 = 0;
    x_hist2 = 0;
    y_hist1 = 0;
    y_hist2 = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_pass_through();
    test_unity_gain();
    test_half_rounding();
    test_saturation();
    test_spare_index();
    test_bypass_keeps_history();
    test_random_coefficients();
    test_output_stall();

    drain_results();
    repeat (LATENCY + 8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("biquad_lowpass_filter regression: pass");
    end else begin
      $display("biquad_lowpass_filter regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
hdl/bqlp_pkg.sv
hdl/bqlp_cfg.sv
hdl/bqlp_ff.sv
hdl/bqlp_fb.sv
hdl/biquad_lowpass_filter.sv
hdl/bqlp_checker.sv
dv/biquad_lowpass_filter_tb.sv
